// ----- rtl/gnps_pkg.sv -----
// Shared types and constants for the grid nearest point search block.
package gnps_pkg;
  localparam int unsigned MaxColsDefault = 256;
  localparam int unsigned MaxRowsDefault = 256;
  localparam int unsigned CoordFracDefault = 8;
  localparam int unsigned MaxPassesDefault = 4096;

  localparam logic [1:0] StatusFound = 2'd0;
  localparam logic [1:0] StatusOutOfBounds = 2'd1;
  localparam logic [1:0] StatusPassLimit = 2'd2;

  localparam logic CfgGridCols = 1'b0;
  localparam logic CfgGridRows = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BOUND,
    ST_READ,
    ST_WAIT,
    ST_LERP,
    ST_ROW,
    ST_DIST,
    ST_CMP,
    ST_NEXT,
    ST_DONE
  } state_t;

  // Round half to even on a count of eighths; returns the cell index.
  function automatic logic signed [13:0] round_cell(input logic signed [13:0] p);
    logic signed [13:0] q;
    logic [2:0] f;
    begin
      q = p >>> 3;
      f = p[2:0];
      if (f > 3'd4 || (f == 3'd4 && q[0])) q = q + 14'sd1;
      return q;
    end
  endfunction
endpackage

// ----- rtl/gnps_grid_mem.sv -----
// Grid point store: one write port, one registered read port.
module gnps_grid_mem #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [95:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [95:0]   rdata
);
  logic [95:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/grid_nearest_point_search.sv -----
// Top level of the grid nearest point search block.
// A query evaluates each candidate by bound check, one read issue, four corner captures,
// two blend steps, distance, compare and advance; a start outside goes from the bound
// check straight to the result.
// Throughput: one item at a time; the next item waits until the result is taken.
// Reset: synchronous; clears control state, sets both sizes to maximum (at most 256); grid memory undefined.
module grid_nearest_point_search #(
  parameter int unsigned MAX_COLS = gnps_pkg::MaxColsDefault,
  parameter int unsigned MAX_ROWS = gnps_pkg::MaxRowsDefault,
  parameter int unsigned COORD_FRAC_BITS = gnps_pkg::CoordFracDefault,
  parameter int unsigned MAX_PASSES = gnps_pkg::MaxPassesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [7:0]         grid_row,
  input  logic [7:0]         grid_col,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic [10:0]        start_col_pos,
  input  logic [10:0]        start_row_pos,
  input  logic               two_axis,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [11:0] found_col_pos,
  output logic signed [11:0] found_row_pos,
  output logic signed [31:0] found_x,
  output logic signed [31:0] found_y,
  output logic signed [31:0] found_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_data
);
  import gnps_pkg::*;

  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned AW = CW + RW;
  localparam int unsigned PW = $clog2(MAX_PASSES + 1);
  localparam logic [12:0] MaxCols13 = 13'(MAX_COLS);
  localparam logic [12:0] MaxRows13 = 13'(MAX_ROWS);

  // Configuration: saturate to the maximum.
  logic [12:0] grid_cols, grid_rows;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= (MaxCols13 < 13'd256) ? MaxCols13 : 13'd256;
      grid_rows <= (MaxRows13 < 13'd256) ? MaxRows13 : 13'd256;
    end else if (cfg_valid) begin
      if (cfg_index == CfgGridCols)
        grid_cols <= ({4'd0, cfg_data} > MaxCols13) ? MaxCols13 : {4'd0, cfg_data};
      else
        grid_rows <= ({4'd0, cfg_data} > MaxRows13) ? MaxRows13 : {4'd0, cfg_data};
    end
  end

  state_t state, state_next;
  logic signed [31:0] tgt [3];
  logic signed [13:0] col, row;      // best position
  logic signed [13:0] cc, cr;        // position under evaluation
  logic               axis2;
  logic [1:0]         step_level;
  logic [1:0]         off_idx;
  logic [PW-1:0]      pass_count;
  logic               changed, first_eval;
  logic [63:0]        best_distance;
  logic signed [31:0] best_pt [3];
  logic signed [31:0] val [3];
  logic [1:0]         rd_cnt;
  logic signed [31:0] g [4][3];
  logic signed [39:0] p0 [3], p1 [3];
  logic [63:0]        sq [3];
  logic [1:0]         res_status;

  // Memory access: loads write; the search reads four corners in turn.
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [95:0]   mem_rdata;
  logic [13:0]   rd_r, rd_c;

  assign mem_we = in_valid && in_ready && !kind &&
                  ({6'd0, grid_row} < 14'(MAX_ROWS)) && ({6'd0, grid_col} < 14'(MAX_COLS));
  assign mem_waddr = AW'(32'(grid_row) * 32'(MAX_COLS) + 32'(grid_col));
  assign rd_c = 14'(cc >>> 3) + {13'd0, rd_cnt[0]};
  assign rd_r = 14'(cr >>> 3) + {13'd0, rd_cnt[1]};
  assign mem_raddr = AW'(32'(rd_r) * 32'(MAX_COLS) + 32'(rd_c));

  gnps_grid_mem #(.DEPTH(MAX_ROWS * MAX_COLS), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata({coord_z, coord_y, coord_x}),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // A corner beyond the store reads as zero.
  logic rd_oob, rd_oob_q;
  assign rd_oob = (rd_r >= 14'(MAX_ROWS)) || (rd_c >= 14'(MAX_COLS));

  // Bounds check on the position under evaluation.
  logic signed [13:0] rc, rr;
  logic               in_bounds;
  assign rc = round_cell(cc);
  assign rr = round_cell(cr);
  assign in_bounds = rc >= 14'sd1 && rc <= $signed({1'b0, grid_cols}) - 14'sd2 &&
                     rr >= 14'sd1 && rr <= $signed({1'b0, grid_rows}) - 14'sd2;

  // Next candidate: offset index and step level after the current evaluation.
  // The first pass starts right after the start point; a pass ends at its last
  // offset, and an unchanged pass drops to the next finer step.
  logic               last_off;
  logic [1:0]         nxt_idx, nxt_lvl;
  logic signed [13:0] st, dcol, drow;
  assign last_off = axis2 ? (off_idx == 2'd3) : (off_idx == 2'd1);
  always_comb begin
    nxt_idx = (pass_count == '0 || last_off) ? 2'd0 : off_idx + 2'd1;
    nxt_lvl = step_level;
    if (pass_count != '0 && last_off && !changed && step_level != 2'd3)
      nxt_lvl = step_level + 2'd1;
    st = 14'sd8 >>> nxt_lvl;
    dcol = '0;
    drow = '0;
    if (axis2) begin
      case (nxt_idx)
        2'd0: drow = -st;
        2'd1: drow = st;
        2'd2: dcol = -st;
        default: dcol = st;
      endcase
    end else begin
      dcol = nxt_idx[0] ? -st : st;
    end
  end

  logic [63:0] dsum;
  logic [64:0] s01, s012;
  always_comb begin
    s01 = {1'b0, sq[0]} + {1'b0, sq[1]};
    s012 = {1'b0, s01[63:0]} + {1'b0, sq[2]};
    if (s01[64] || s012[64]) dsum = '1;
    else dsum = s012[63:0];
  end

  assign in_ready = (state == ST_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid && in_ready && kind) state_next = ST_BOUND;
      ST_BOUND: state_next = in_bounds ? ST_READ : ST_DONE;
      ST_READ:  state_next = ST_WAIT;
      ST_WAIT:  state_next = (rd_cnt == 2'd0) ? ST_LERP : ST_WAIT;
      ST_LERP:  state_next = ST_ROW;
      ST_ROW:   state_next = ST_DIST;
      ST_DIST:  state_next = ST_CMP;
      ST_CMP:   state_next = ST_NEXT;
      ST_NEXT: begin
        // Stop when the finest step brings nothing or the pass cap is reached.
        if (pass_count != '0 && last_off &&
            ((!changed && step_level == 2'd3) || pass_count >= PW'(MAX_PASSES)))
          state_next = ST_DONE;
        else
          state_next = ST_BOUND;
      end
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  logic [2:0] fx, fy;
  assign fx = cc[2:0];
  assign fy = cr[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      rd_cnt <= '0;
      step_level <= '0;
      pass_count <= '0;
      off_idx <= '0;
      changed <= 1'b0;
      first_eval <= 1'b0;
      res_status <= StatusFound;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready && kind) begin
            tgt[0] <= coord_x;
            tgt[1] <= coord_y;
            tgt[2] <= coord_z;
            cc <= {3'd0, start_col_pos};
            cr <= {3'd0, start_row_pos};
            col <= {3'd0, start_col_pos};
            row <= {3'd0, start_row_pos};
            axis2 <= two_axis;
            step_level <= '0;
            pass_count <= '0;
            off_idx <= '0;
            first_eval <= 1'b1;
            res_status <= StatusFound;
          end
        end
        ST_BOUND: begin
          rd_cnt <= '0;
          if (!in_bounds) res_status <= StatusOutOfBounds;
        end
        ST_READ: begin
          rd_oob_q <= rd_oob;
          rd_cnt <= rd_cnt + 2'd1;
        end
        ST_WAIT: begin
          // Capture the corner issued last cycle; issue the next one.
          for (int k = 0; k < 3; k++)
            g[rd_cnt - 2'd1][k] <= rd_oob_q ? 32'sd0 : $signed(mem_rdata[32*k +: 32]);
          rd_oob_q <= rd_oob;
          if (rd_cnt != 2'd0) rd_cnt <= rd_cnt + 2'd1;
        end
        ST_LERP: begin
          for (int k = 0; k < 3; k++) begin
            p0[k] <= $signed({1'b0, 4'd8 - {1'b0, fx}}) * 40'(g[0][k]) +
                     $signed({2'b0, fx}) * 40'(g[1][k]);
            p1[k] <= $signed({1'b0, 4'd8 - {1'b0, fx}}) * 40'(g[2][k]) +
                     $signed({2'b0, fx}) * 40'(g[3][k]);
          end
        end
        ST_ROW: begin
          for (int k = 0; k < 3; k++)
            val[k] <= 32'(($signed({1'b0, 4'd8 - {1'b0, fy}}) * 44'(p0[k]) +
                           $signed({2'b0, fy}) * 44'(p1[k]) + 44'sd32) >>> 6);
        end
        ST_DIST: begin
          for (int k = 0; k < 3; k++) begin
            logic signed [32:0] d;
            logic [32:0] m;
            d = 33'(val[k]) - 33'(tgt[k]);
            m = d[32] ? 33'(-d) : d;
            sq[k] <= 64'(m[31:0]) * 64'(m[31:0]) + (m[32] ? 64'h4000_0000_0000_0000 : 64'd0);
          end
        end
        ST_CMP: begin
          if (first_eval || dsum < best_distance) begin
            if (!first_eval) changed <= 1'b1;
            best_distance <= dsum;
            col <= cc;
            row <= cr;
            best_pt <= val;
          end
          first_eval <= 1'b0;
        end
        ST_NEXT: begin
          // Advance to the next candidate, pass or step level.
          cc <= col + dcol;
          cr <= row + drow;
          off_idx <= nxt_idx;
          step_level <= nxt_lvl;
          if (pass_count == '0) begin
            pass_count <= PW'(1);
            changed <= 1'b0;
          end else if (last_off && (changed || step_level != 2'd3)) begin
            if (pass_count >= PW'(MAX_PASSES)) begin
              res_status <= StatusPassLimit;
            end else begin
              pass_count <= pass_count + PW'(1);
              changed <= 1'b0;
            end
          end
        end
        ST_DONE: begin
          out_valid <= 1'b1;
          status <= res_status;
          if (res_status == StatusOutOfBounds) begin
            found_col_pos <= -12'sd8;
            found_row_pos <= -12'sd8;
            found_x <= -(32'sd1 <<< COORD_FRAC_BITS);
            found_y <= -(32'sd1 <<< COORD_FRAC_BITS);
            found_z <= -(32'sd1 <<< COORD_FRAC_BITS);
          end else begin
            found_col_pos <= col[11:0];
            found_row_pos <= row[11:0];
            found_x <= best_pt[0];
            found_y <= best_pt[1];
            found_z <= best_pt[2];
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for grid_nearest_point_search: loads, queries and size changes.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gnps_pkg::*;

  localparam int GridDim = 256;

  // One expected or observed search result.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [11:0] col_pos;
    logic signed [11:0] row_pos;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } search_result_t;

  // Mirror of the grid memory and size registers; predicts one result per query.
  class search_board;
    int             mem_x[GridDim*GridDim];
    int             mem_y[GridDim*GridDim];
    int             mem_z[GridDim*GridDim];
    int             cols = GridDim;
    int             rows = GridDim;
    search_result_t pending_results[$];
    int             fails;

    function void set_size(logic idx, logic [8:0] val);
      int v;
      v = (val > GridDim) ? GridDim : int'(val);
      if (idx == CfgGridCols) cols = v;
      else rows = v;
    endfunction

    function int round_cell(int p);
      int q;
      q = p >>> 3;
      if ((p & 7) > 4 || ((p & 7) == 4 && q[0])) q++;
      return q;
    endfunction

    function bit on_grid(int c, int r);
      int rc, rr;
      rc = round_cell(c);
      rr = round_cell(r);
      return rc >= 1 && rc <= cols - 2 && rr >= 1 && rr <= rows - 2;
    endfunction

    function longint corner(int r, int c, int k);
      int a;
      a = r * GridDim + c;
      if (r >= GridDim || c >= GridDim) return 0;
      return (k == 0) ? mem_x[a] : (k == 1) ? mem_y[a] : mem_z[a];
    endfunction

    // Bilinear blend in eighths, rounded half up.
    function void blend(int c, int r, output int v[3]);
      int x, fx, y, fy;
      longint p0, p1, s;
      x = c >> 3; fx = c & 7;
      y = r >> 3; fy = r & 7;
      for (int k = 0; k < 3; k++) begin
        p0 = (8 - fx) * corner(y, x, k) + fx * corner(y, x + 1, k);
        p1 = (8 - fx) * corner(y + 1, x, k) + fx * corner(y + 1, x + 1, k);
        s = (8 - fy) * p0 + fy * p1;
        v[k] = int'((s + 32) >>> 6);
      end
    endfunction

    function longint unsigned dist2(int v[3], int t[3]);
      longint unsigned sum, m, sq;
      longint d;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        d = longint'(v[k]) - longint'(t[k]);
        m = (d < 0) ? -d : d;
        sq = m * m;
        if (sum > ~64'd0 - sq) sum = ~64'd0;
        else sum += sq;
      end
      return sum;
    endfunction

    // Note an accepted item; a query pushes its predicted result.
    function void note_item(logic kind, logic [7:0] gr, logic [7:0] gc,
                            int cx, int cy, int cz, int sc, int sr, logic two);
      int dcol[4], drow[4], tgt[3], val[3], best[3];
      int col, row, noff, lvl, passes, cc, cr;
      bit moved, fail;
      longint unsigned bd, d;
      search_result_t res;
      if (!kind) begin
        mem_x[gr * GridDim + gc] = cx;
        mem_y[gr * GridDim + gc] = cy;
        mem_z[gr * GridDim + gc] = cz;
        return;
      end
      tgt = '{cx, cy, cz};
      if (two) begin
        dcol = '{0, 0, -1, 1}; drow = '{-1, 1, 0, 0}; noff = 4;
      end else begin
        dcol = '{1, -1, 0, 0}; drow = '{0, 0, 0, 0}; noff = 2;
      end
      col = sc; row = sr; lvl = 0; passes = 0;
      moved = 1; fail = 0;
      res.status = StatusFound;
      if (!on_grid(col, row)) begin
        fail = 1;
      end else begin
        blend(col, row, best);
        bd = dist2(best, tgt);
        while (moved && !fail) begin
          if (passes >= MaxPassesDefault) begin
            res.status = StatusPassLimit;
            break;
          end
          passes++;
          moved = 0;
          for (int i = 0; i < noff; i++) begin
            cc = col + dcol[i] * (8 >> lvl);
            cr = row + drow[i] * (8 >> lvl);
            if (!on_grid(cc, cr)) begin
              fail = 1;
              break;
            end
            blend(cc, cr, val);
            d = dist2(val, tgt);
            if (d < bd) begin
              moved = 1; bd = d; col = cc; row = cr; best = val;
            end
          end
          if (!fail && !moved && lvl < 3) begin
            lvl++;
            moved = 1;
          end
        end
      end
      if (fail) begin
        res.status = StatusOutOfBounds;
        col = -8; row = -8;
        best = '{-(1 << CoordFracDefault), -(1 << CoordFracDefault),
                 -(1 << CoordFracDefault)};
      end
      res.col_pos = col[11:0]; res.row_pos = row[11:0];
      res.px = best[0]; res.py = best[1]; res.pz = best[2];
      pending_results.push_back(res);
    endfunction

    function void check_result(search_result_t got);
      search_result_t want;
      if (pending_results.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result status=%0d", got.status);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10)
          $display({"mismatch: expected st=%0d pos=(%0d,%0d) pt=(%0d,%0d,%0d)",
                    " got st=%0d pos=(%0d,%0d) pt=(%0d,%0d,%0d)"},
                   want.status, want.col_pos, want.row_pos, want.px, want.py, want.pz,
                   got.status, got.col_pos, got.row_pos, got.px, got.py, got.pz);
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic               kind = 0;
  logic [7:0]         grid_row = 0;
  logic [7:0]         grid_col = 0;
  logic signed [31:0] coord_x = 0;
  logic signed [31:0] coord_y = 0;
  logic signed [31:0] coord_z = 0;
  logic [10:0]        start_col_pos = 0;
  logic [10:0]        start_row_pos = 0;
  logic               two_axis = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [1:0]         status;
  logic signed [11:0] found_col_pos;
  logic signed [11:0] found_row_pos;
  logic signed [31:0] found_x;
  logic signed [31:0] found_y;
  logic signed [31:0] found_z;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic               cfg_index = 0;
  logic [8:0]         cfg_data = 0;

  search_board board = new();
  bit          gaps_on = 1;     // random idling on both sides
  int          results_seen;
  int          cur_cols = GridDim;
  int          cur_rows = GridDim;

  grid_nearest_point_search dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Watch all three handshakes at the clock edge and feed the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.set_size(cfg_index, cfg_data);
      if (in_valid && in_ready)
        board.note_item(kind, grid_row, grid_col, coord_x, coord_y, coord_z,
                        start_col_pos, start_row_pos, two_axis);
      if (out_valid && out_ready) begin
        board.check_result('{status, found_col_pos, found_row_pos,
                             found_x, found_y, found_z});
        results_seen++;
      end
    end
  end

  // Result sink: random back-pressure plus one long hold so the block backs up.
  initial begin : sink
    bit held;
    held = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (results_seen == 15 && !held) begin
        held = 1;
        out_ready <= 0;
        repeat (3000) @(posedge clk);
      end
      out_ready <= gaps_on ? ($urandom_range(99) >= 26) : 1'b1;
    end
  end

  // Offer one item; hold valid and payload until the block takes it.
  task automatic send_item(int k, int gr, int gc, int cx, int cy,
                           int cz, int sc, int sr, int two);
    while (gaps_on && $urandom_range(99) < 26) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    kind <= 1'(k); grid_row <= 8'(gr); grid_col <= 8'(gc);
    coord_x <= cx; coord_y <= cy; coord_z <= cz;
    start_col_pos <= 11'(sc); start_row_pos <= 11'(sr); two_axis <= 1'(two);
    do @(posedge clk); while (!in_ready);
  endtask

  // Drain every outstanding result, then let a trailing load settle.
  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (board.pending_results.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_size(logic idx, int val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= 9'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == CfgGridCols) cur_cols = (val > GridDim) ? GridDim : val;
    else cur_rows = (val > GridDim) ? GridDim : val;
  endtask

  // Load a smooth surface over the active grid, with the odd wild point.
  task automatic load_grid();
    for (int r = 0; r < cur_rows; r++)
      for (int c = 0; c < cur_cols; c++) begin
        if ($urandom_range(19) == 0)
          send_item(0, r, c, $urandom, $urandom, $urandom, 0, 0, 0);
        else
          send_item(0, r, c, c * 1024 + $urandom_range(600) - 300,
                    r * 1024 + $urandom_range(600) - 300,
                    (c * r * 97) % 4000 - $urandom_range(2000), 0, 0, 0);
      end
  endtask

  // Random query over a fully loaded grid; mostly in-range starts and nearby targets.
  task automatic random_query();
    int sc, sr, tx, ty, tz;
    if ($urandom_range(9) == 0) begin
      sc = $urandom_range(2047);
      sr = $urandom_range(2047);
    end else begin
      sc = $urandom_range(8 * cur_cols - 13, 5);
      sr = $urandom_range(8 * cur_rows - 13, 5);
    end
    if ($urandom_range(7) == 0) begin
      tx = $urandom; ty = $urandom; tz = $urandom;
    end else begin
      tx = $urandom_range(cur_cols * 1024) - 512;
      ty = $urandom_range(cur_rows * 1024) - 512;
      tz = $urandom_range(8000) - 4000;
    end
    send_item(1, $urandom_range(255), $urandom_range(255), tx, ty, tz, sc, sr,
              $urandom_range(1));
  endtask

  task automatic run_phase(logic [8:0] ncols, logic [8:0] nrows, int nq);
    drain();
    write_size(CfgGridCols, ncols);
    write_size(CfgGridRows, nrows);
    load_grid();
    for (int i = 0; i < nq; i++) begin
      if ($urandom_range(5) == 0)
        send_item(0, $urandom_range(cur_rows - 1), $urandom_range(cur_cols - 1),
                  $urandom_range(cur_cols * 1024), $urandom_range(cur_rows * 1024),
                  $urandom_range(4000), 0, 0, 0);
      else
        random_query();
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: smallest grid, extreme points, rounding ties at the edges.
    write_size(CfgGridCols, 3);
    write_size(CfgGridRows, 3);
    send_item(0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
    send_item(0, 0, 1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
    send_item(0, 255, 255, -1, -1, -1, 0, 0, 0);
    for (int r = 0; r < 3; r++)
      for (int c = (r == 0) ? 2 : 0; c < 3; c++)
        send_item(0, r, c, c * 256, r * 256, 0, 0, 0, 0);
    send_item(1, 0, 0, 256, 256, 0, 8, 8, 1);         // centered, two axes
    send_item(1, 0, 0, 256, 256, 0, 8, 8, 0);         // centered, column only
    send_item(1, 0, 0, 0, 0, 0, 4, 8, 1);             // tie rounds down to even: outside
    send_item(1, 0, 0, 0, 0, 0, 12, 8, 0);            // tie rounds up to even: outside
    send_item(1, 0, 0, 0, 0, 0, 5, 11, 1);            // innermost corners stay inside
    send_item(1, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 11, 5, 0);
    send_item(1, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8, 8, 1);
    send_item(1, 0, 0, 0, 0, 0, 2047, 2047, 1);
    send_item(1, 0, 0, 0, 0, 0, 0, 0, 0);

    // Sizes below three: every query is out of bounds, nothing is read.
    drain();
    write_size(CfgGridCols, 0);
    write_size(CfgGridRows, 2);
    for (int i = 0; i < 6; i++)
      send_item(1, 0, 0, $urandom, $urandom, $urandom, $urandom_range(2047),
                $urandom_range(2047), i[0]);

    // Largest and oversized settings: only starts off the grid edge.
    drain();
    write_size(CfgGridCols, 9'h1ff);
    write_size(CfgGridRows, 256);
    for (int i = 0; i < 8; i++)
      send_item(1, 0, 0, $urandom, $urandom, $urandom,
                i[0] ? $urandom_range(3) : $urandom_range(2047, 2037),
                $urandom_range(2047), i[1]);

    run_phase(4, 5, 40);
    run_phase(8, 6, 60);
    gaps_on = 0;                                      // back-to-back stretch
    run_phase(16, 12, 100);
    gaps_on = 1;
    run_phase(5, 16, 60);
    run_phase(3, 7, 30);
    run_phase(12, 3, 40);

    drain();
    if (board.fails == 0 && board.pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin : watchdog
    #200ms;
    $display("tb_top failed");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/gnps_pkg.sv
rtl/gnps_grid_mem.sv
rtl/grid_nearest_point_search.sv
tb/tb_top.sv
